[design/twr_pkg.sv]
package twr_pkg;

  localparam int CHANNELS   = 16;
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int MODE_W     = 2;
  localparam int CHAN_W     = 4;
  localparam int TIME_W     = 32;
  localparam int CNT_W      = 32;
  localparam int LIMIT_W    = 32;
  localparam int CFG_IDX_W  = 1;

  localparam int IN_FIELDS_W  = CHAN_W + TIME_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + TIME_W + CNT_W + 1 + 1;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [LIMIT_W-1:0] STUCK_LIMIT_RST   = LIMIT_W'(60 * 1000);
  localparam logic [LIMIT_W-1:0] RESTART_LIMIT_RST = LIMIT_W'(10 * 60 * 1000);

  typedef enum logic [MODE_W-1:0] {
    MODE_START = 2'd0,
    MODE_END   = 2'd1,
    MODE_CHECK = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STUCK_LIMIT   = 1'b0,
    REG_RESTART_LIMIT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    mode_t               mode;
    logic [CHAN_W-1:0]   channel;
    logic [TIME_W-1:0]   now_ms;
  } item_t;

  typedef struct packed {
    logic                restart_request;
    logic                stuck;
    logic [CNT_W-1:0]    run_count_out;
    logic [TIME_W-1:0]   elapsed_ms;
    logic                active;
  } result_t;

endpackage

[design/twr_in_stage.sv]
module twr_in_stage
  import twr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [MODE_W-1:0]     in_tuser,
  input  logic                  advance,
  output logic                  item_valid,
  output item_t                 item
);

  logic  valid_r;
  item_t item_r;
  item_t item_nxt;

  assign in_tready = !valid_r || advance;

  always_comb begin
    item_nxt.mode    = mode_t'(in_tuser);
    item_nxt.channel = in_tdata[CHAN_W-1:0];
    item_nxt.now_ms  = in_tdata[CHAN_W +: TIME_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

[design/twr_chan_state.sv]
module twr_chan_state
  import twr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [LIMIT_W-1:0]    cfg_wdata,
  input  logic                  item_valid,
  input  item_t                 item,
  input  logic                  advance,
  output result_t               result
);

  logic [LIMIT_W-1:0]  stuck_limit_r;
  logic [LIMIT_W-1:0]  restart_limit_r;

  logic [TIME_W-1:0]   start_stamp_r   [CHANNELS];
  logic [TIME_W-1:0]   last_duration_r [CHANNELS];
  logic [CNT_W-1:0]    run_count_r     [CHANNELS];
  logic [CNT_W-1:0]    seen_count_r    [CHANNELS];
  logic [CHANNELS-1:0] stuck_flag_r;

  logic [CH_IDX_W-1:0] idx;
  logic                ch_ok;
  logic [TIME_W-1:0]   ss;
  logic [TIME_W-1:0]   ld;
  logic [CNT_W-1:0]    rc;
  logic [CNT_W-1:0]    seen;
  logic                stk;
  logic [TIME_W-1:0]   since_start;
  logic                act_pre;

  logic [TIME_W-1:0]   ss_nxt;
  logic [TIME_W-1:0]   ld_nxt;
  logic [CNT_W-1:0]    rc_nxt;
  logic [CNT_W-1:0]    seen_nxt;
  logic                stk_nxt;
  logic [TIME_W-1:0]   elapsed;
  logic                restart;
  logic                wr_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stuck_limit_r   <= STUCK_LIMIT_RST;
      restart_limit_r <= RESTART_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_STUCK_LIMIT:   stuck_limit_r   <= cfg_wdata;
        REG_RESTART_LIMIT: restart_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign ch_ok = 32'(item.channel) < 32'(CHANNELS);
  assign idx   = CH_IDX_W'(item.channel);

  assign ss          = start_stamp_r[idx];
  assign ld          = last_duration_r[idx];
  assign rc          = run_count_r[idx];
  assign seen        = seen_count_r[idx];
  assign stk         = stuck_flag_r[idx];
  assign since_start = item.now_ms - ss;
  assign act_pre     = (ld != '0) || (rc != '0);

  always_comb begin
    ss_nxt   = ss;
    ld_nxt   = ld;
    rc_nxt   = rc;
    seen_nxt = seen;
    stk_nxt  = stk;
    elapsed  = '0;
    restart  = 1'b0;
    unique case (item.mode)
      MODE_START: begin
        ss_nxt = item.now_ms;
      end
      MODE_END: begin
        ld_nxt = since_start;
        rc_nxt = rc + CNT_W'(1);
      end
      MODE_CHECK: begin
        if (act_pre) begin
          elapsed = (rc != seen) ? ld : since_start;
          if (elapsed > stuck_limit_r) begin
            stk_nxt = 1'b1;
            restart = elapsed > restart_limit_r;
          end
          seen_nxt = rc;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result = '0;
    if (ch_ok) begin
      result.active          = (ld_nxt != '0) || (rc_nxt != '0);
      result.elapsed_ms      = elapsed;
      result.run_count_out   = rc_nxt;
      result.stuck           = stk_nxt;
      result.restart_request = restart;
    end
  end

  assign wr_en = item_valid && advance && ch_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        start_stamp_r[i]   <= '0;
        last_duration_r[i] <= '0;
        run_count_r[i]     <= '0;
        seen_count_r[i]    <= '0;
      end
      stuck_flag_r <= '0;
    end else if (wr_en) begin
      start_stamp_r[idx]   <= ss_nxt;
      last_duration_r[idx] <= ld_nxt;
      run_count_r[idx]     <= rc_nxt;
      seen_count_r[idx]    <= seen_nxt;
      stuck_flag_r[idx]    <= stk_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_stuck_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(stuck_flag_r) & ~stuck_flag_r) == '0)
    else $error("stuck flag cleared outside reset");

  a_restart_implies_stuck: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && result.restart_request) |-> result.stuck)
    else $error("restart request without stuck flag");

  a_measure_only_on_check: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && (result.restart_request || (result.elapsed_ms != '0)))
      |-> (item.mode == MODE_CHECK))
    else $error("measurement reported outside a check");

  a_inactive_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && !result.active)
      |-> ((result.elapsed_ms == '0) && !result.restart_request))
    else $error("inactive channel reported a measurement");
`endif

endmodule

[design/twr_out_stage.sv]
module twr_out_stage
  import twr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  result_t               result,
  output logic                  free,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic    valid_r;
  result_t data_r;

  assign free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = OUT_DATA_W'(data_r);

endmodule

[design/task_runtime_watchdog.sv]
// channel  direction  handshake              payload
// in_      slave      in_tvalid/in_tready    tuser: mode; tdata: channel, now_ms
// out_     master     out_tvalid/out_tready  tdata: active, elapsed_ms, run_count_out,
//                                                   stuck, restart_request
// cfg_     write      cfg_we                 cfg_index, cfg_wdata
//
// One item per cycle while out_tready is high; items go from input to output register.
// Each item does one channel table lookup, one 32-bit subtract and two limit compares.
// Synchronous active-low reset clears the channel table and loads default limits.
// A stalled output holds its item; one more item waits in the input register.
module task_runtime_watchdog
  import twr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // channel, now_ms, zero pad
  input  logic [MODE_W-1:0]     in_tuser,   // mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // active, elapsed_ms, run_count_out,
                                            // stuck, restart_request, zero pad
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [LIMIT_W-1:0]    cfg_wdata
);

  logic    item_valid;
  item_t   item;
  result_t result;
  logic    free;
  logic    advance;

  assign advance = item_valid && free;

  twr_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  twr_chan_state u_chan_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .result     (result)
  );

  twr_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result     (result),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
